// ----- rtl/core/sfhc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfhc_pkg
// shared types and constants of the solar flow hysteresis controller
// ----------------------------------------------------------------------------
package sfhc_pkg;

    // field widths
    localparam int unsigned TEMP_W  = 13;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned MS_W    = 27;
    localparam int unsigned BAND_W  = 10;
    localparam int unsigned RPM_W   = 16;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MASK_W  = 5;
    localparam int unsigned CIDX_W  = 3;
    // width for temperature sums with a band or offset added
    localparam int unsigned SUM_W   = 15;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [TIME_W-1:0]        time_t;
    typedef logic [MS_W-1:0]          ms_t;
    typedef logic [BAND_W-1:0]        band_t;
    typedef logic [HOUR_W-1:0]        hour_t;
    typedef logic [MASK_W-1:0]        mask_t;
    typedef logic [CIDX_W-1:0]        cidx_t;

    // thresholds
    localparam logic [RPM_W-1:0] RPM_MIN    = 16'd100;
    localparam hour_t            PEAK_START = 5'd16;
    localparam hour_t            PEAK_END   = 5'd21;
    localparam hour_t            DAY_START  = 5'd8;
    localparam hour_t            DAY_END    = 5'd19;

    // presence mask bits
    localparam int unsigned PM_PUMP  = 0;
    localparam int unsigned PM_WATER = 1;
    localparam int unsigned PM_PANEL = 2;
    localparam int unsigned PM_HEAT  = 3;
    localparam int unsigned PM_COOL  = 4;

    typedef enum logic [1:0] {
        DS_UNKNOWN = 2'd0,
        DS_IDLE    = 2'd1,
        DS_FLOWING = 2'd2
    } desired_t;

    typedef enum logic [2:0] {
        RSN_NO_PUMP      = 3'd0,
        RSN_PUMP_OFF     = 3'd1,
        RSN_PEAK         = 3'd2,
        RSN_MISSING_WAIT = 3'd3,
        RSN_MISSING_TOUT = 3'd4,
        RSN_HEAT         = 3'd5,
        RSN_COOL         = 3'd6
    } reason_t;

    // configuration register indexes
    localparam cidx_t CFG_POOL_TOL    = 3'd0;
    localparam cidx_t CFG_SPA_TOL     = 3'd1;
    localparam cidx_t CFG_START_OFS   = 3'd2;
    localparam cidx_t CFG_STOP_OFS    = 3'd3;
    localparam cidx_t CFG_MISS_TOUT   = 3'd4;
    localparam cidx_t CFG_MIN_DWELL   = 3'd5;

    // configuration reset values
    localparam band_t RST_POOL_TOL  = 10'd16;
    localparam band_t RST_SPA_TOL   = 10'd8;
    localparam band_t RST_START_OFS = 10'd64;
    localparam band_t RST_STOP_OFS  = 10'd16;
    localparam ms_t   RST_MISS_TOUT = 27'd300000;
    localparam ms_t   RST_MIN_DWELL = 27'd120000;

    // one poll word as held in the input register
    typedef struct packed {
        time_t  now_ms;
        mask_t  present_mask;
        logic [RPM_W-1:0] pump_rpm;
        hour_t  hour_of_day;
        logic   spa_active;
        temp_t  water_temp;
        temp_t  panel_temp;
        temp_t  heat_target;
        temp_t  cool_target;
    } poll_t;

endpackage

// ----- rtl/core/sfhc_poll_if.sv -----
// ----------------------------------------------------------------------------
// sfhc_poll_if
// poll channel: one word of sensor data per handshake
// ----------------------------------------------------------------------------
interface sfhc_poll_if;
    logic                  valid;
    logic                  ready;
    sfhc_pkg::time_t       now_ms;
    sfhc_pkg::mask_t       present_mask;
    logic [15:0]           pump_rpm;
    sfhc_pkg::hour_t       hour_of_day;
    logic                  spa_active;
    sfhc_pkg::temp_t       water_temp;
    sfhc_pkg::temp_t       panel_temp;
    sfhc_pkg::temp_t       heat_target;
    sfhc_pkg::temp_t       cool_target;

    modport source (
        output valid, now_ms, present_mask, pump_rpm, hour_of_day, spa_active,
               water_temp, panel_temp, heat_target, cool_target,
        input  ready
    );
    modport sink (
        input  valid, now_ms, present_mask, pump_rpm, hour_of_day, spa_active,
               water_temp, panel_temp, heat_target, cool_target,
        output ready
    );
endinterface

// ----- rtl/core/sfhc_result_if.sv -----
// ----------------------------------------------------------------------------
// sfhc_result_if
// result channel: one decision word per handshake
// ----------------------------------------------------------------------------
interface sfhc_result_if;
    logic       valid;
    logic       ready;
    logic       flow_on;
    logic       flow_changed;
    logic [1:0] desired_flow;
    logic [2:0] decision_reason;

    modport source (
        output valid, flow_on, flow_changed, desired_flow, decision_reason,
        input  ready
    );
    modport sink (
        input  valid, flow_on, flow_changed, desired_flow, decision_reason,
        output ready
    );
endinterface

// ----- rtl/core/sfhc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// sfhc_cfg_if
// configuration write channel: register index and data per word
// ----------------------------------------------------------------------------
interface sfhc_cfg_if;
    logic                  valid;
    logic                  ready;
    sfhc_pkg::cidx_t       wr_index;
    logic [26:0]           wr_data;

    modport source (
        output valid, wr_index, wr_data,
        input  ready
    );
    modport sink (
        input  valid, wr_index, wr_data,
        output ready
    );
endinterface

// ----- rtl/core/solar_flow_hysteresis_controller.sv -----
// ----------------------------------------------------------------------------
// solar_flow_hysteresis_controller
// path: a poll word is held in the input register, then moves into the result register
// throughput: one poll word per cycle unless the result side stalls; the decision
//   and the state update are done in one pass between the input and result registers
// reset: asynchronous, active low; clears flow state, desired state, timers
//   and the configuration registers to their defaults
// ----------------------------------------------------------------------------
module solar_flow_hysteresis_controller (
    input  logic          clk,
    input  logic          rst_n,
    sfhc_poll_if.sink     poll,
    sfhc_result_if.source result,
    sfhc_cfg_if.sink      cfg
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    sfhc_pkg::band_t pool_tol_reg;
    sfhc_pkg::band_t spa_tol_reg;
    sfhc_pkg::band_t start_ofs_reg;
    sfhc_pkg::band_t stop_ofs_reg;
    sfhc_pkg::ms_t   miss_tout_reg;
    sfhc_pkg::ms_t   min_dwell_reg;

    // configuration writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_tol_reg  <= sfhc_pkg::RST_POOL_TOL;
            spa_tol_reg   <= sfhc_pkg::RST_SPA_TOL;
            start_ofs_reg <= sfhc_pkg::RST_START_OFS;
            stop_ofs_reg  <= sfhc_pkg::RST_STOP_OFS;
            miss_tout_reg <= sfhc_pkg::RST_MISS_TOUT;
            min_dwell_reg <= sfhc_pkg::RST_MIN_DWELL;
        end
        else if (cfg.valid)
        begin
            case (cfg.wr_index)
                sfhc_pkg::CFG_POOL_TOL:  pool_tol_reg  <= cfg.wr_data[9:0];
                sfhc_pkg::CFG_SPA_TOL:   spa_tol_reg   <= cfg.wr_data[9:0];
                sfhc_pkg::CFG_START_OFS: start_ofs_reg <= cfg.wr_data[9:0];
                sfhc_pkg::CFG_STOP_OFS:  stop_ofs_reg  <= cfg.wr_data[9:0];
                sfhc_pkg::CFG_MISS_TOUT: miss_tout_reg <= cfg.wr_data;
                sfhc_pkg::CFG_MIN_DWELL: min_dwell_reg <= cfg.wr_data;
                default: ;  // indexes past the list are ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: input register feeds the result register
    // ------------------------------------------------------------------
    logic            in_valid_reg;
    sfhc_pkg::poll_t in_word_reg;
    logic            out_valid_reg;
    logic            advance;   // input register moves into result register
    logic            take;      // poll word accepted

    // result register frees up when empty or being taken this cycle
    assign advance     = in_valid_reg && (!out_valid_reg || result.ready);
    assign poll.ready  = !in_valid_reg || advance;
    assign take        = poll.valid && poll.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_word_reg.now_ms       <= poll.now_ms;
            in_word_reg.present_mask <= poll.present_mask;
            in_word_reg.pump_rpm     <= poll.pump_rpm;
            in_word_reg.hour_of_day  <= poll.hour_of_day;
            in_word_reg.spa_active   <= poll.spa_active;
            in_word_reg.water_temp   <= poll.water_temp;
            in_word_reg.panel_temp   <= poll.panel_temp;
            in_word_reg.heat_target  <= poll.heat_target;
            in_word_reg.cool_target  <= poll.cool_target;
        end
    end

    // ------------------------------------------------------------------
    // controller state
    // ------------------------------------------------------------------
    logic               flow_state_reg,   flow_state_next;
    sfhc_pkg::desired_t desired_reg,      desired_next;
    sfhc_pkg::time_t    dchg_time_reg,    dchg_time_next;
    logic               miss_active_reg,  miss_active_next;
    sfhc_pkg::time_t    miss_start_reg,   miss_start_next;
    sfhc_pkg::reason_t  reason;

    // ------------------------------------------------------------------
    // decision logic
    // ------------------------------------------------------------------
    sfhc_pkg::mask_t    mask;
    logic               spa;
    sfhc_pkg::hour_t    hour;
    sfhc_pkg::time_t    now;
    sfhc_pkg::sum_t     water_s, panel_s, heat_s, cool_s;
    sfhc_pkg::sum_t     tol_s, ofs_s, lim_s, minp_s, maxp_s;
    logic               is_peak, is_day, all_present;
    sfhc_pkg::time_t    miss_elapsed, dwell_elapsed, miss_start_eff, dchg_eff;
    sfhc_pkg::desired_t want;
    logic               force_idle;   // flow state goes idle
    logic               apply_want;   // dwell satisfied, take the wanted state

    always_comb
    begin
        mask = in_word_reg.present_mask;
        spa  = in_word_reg.spa_active;
        hour = in_word_reg.hour_of_day;
        now  = in_word_reg.now_ms;

        // widen temperatures so band and offset sums cannot overflow
        water_s = sfhc_pkg::sum_t'(in_word_reg.water_temp);
        panel_s = sfhc_pkg::sum_t'(in_word_reg.panel_temp);
        heat_s  = sfhc_pkg::sum_t'(in_word_reg.heat_target);
        cool_s  = sfhc_pkg::sum_t'(in_word_reg.cool_target);

        tol_s = sfhc_pkg::sum_t'({5'd0, spa ? spa_tol_reg : pool_tol_reg});
        ofs_s = sfhc_pkg::sum_t'({5'd0, flow_state_reg ? stop_ofs_reg : start_ofs_reg});

        // heating: band around the target widens once flowing
        lim_s  = flow_state_reg ? (heat_s + tol_s) : (heat_s - tol_s);
        minp_s = water_s + ofs_s;
        // cooling: panel must sit below the water by the offset
        maxp_s = water_s - ofs_s;

        is_peak     = !spa && (hour >= sfhc_pkg::PEAK_START) && (hour < sfhc_pkg::PEAK_END);
        is_day      = (hour >= sfhc_pkg::DAY_START) && (hour <= sfhc_pkg::DAY_END);
        all_present = mask[sfhc_pkg::PM_WATER] && mask[sfhc_pkg::PM_PANEL]
                      && mask[sfhc_pkg::PM_HEAT];

        // missing-data timer starts on the first poll with data missing
        miss_start_eff = miss_active_reg ? miss_start_reg : now;
        miss_elapsed   = now - miss_start_eff;

        if (spa || is_day)
        begin
            if (water_s >= lim_s)
                want = sfhc_pkg::DS_IDLE;
            else
                want = (panel_s >= minp_s) ? sfhc_pkg::DS_FLOWING : sfhc_pkg::DS_IDLE;
        end
        else
        begin
            if (!mask[sfhc_pkg::PM_COOL] || (water_s <= cool_s))
                want = sfhc_pkg::DS_IDLE;
            else
                want = (panel_s <= maxp_s) ? sfhc_pkg::DS_FLOWING : sfhc_pkg::DS_IDLE;
        end

        // dwell restarts whenever the wanted state differs from the held one
        dchg_eff      = (want != desired_reg) ? now : dchg_time_reg;
        dwell_elapsed = now - dchg_eff;

        desired_next     = desired_reg;
        dchg_time_next   = dchg_time_reg;
        miss_active_next = miss_active_reg;
        miss_start_next  = miss_start_reg;
        force_idle       = 1'b0;
        apply_want       = 1'b0;

        if (!mask[sfhc_pkg::PM_PUMP])
        begin
            reason = sfhc_pkg::RSN_NO_PUMP;
        end
        else if (in_word_reg.pump_rpm < sfhc_pkg::RPM_MIN)
        begin
            reason     = sfhc_pkg::RSN_PUMP_OFF;
            force_idle = 1'b1;
        end
        else if (is_peak)
        begin
            reason     = sfhc_pkg::RSN_PEAK;
            force_idle = 1'b1;
        end
        else if (!all_present)
        begin
            miss_active_next = 1'b1;
            miss_start_next  = miss_start_eff;
            if (miss_elapsed >= {5'd0, miss_tout_reg})
            begin
                reason     = sfhc_pkg::RSN_MISSING_TOUT;
                force_idle = 1'b1;
            end
            else
            begin
                reason = sfhc_pkg::RSN_MISSING_WAIT;
            end
        end
        else
        begin
            miss_active_next = 1'b0;
            miss_start_next  = '0;
            reason           = (spa || is_day) ? sfhc_pkg::RSN_HEAT : sfhc_pkg::RSN_COOL;
            desired_next     = want;
            dchg_time_next   = dchg_eff;
            apply_want       = (dwell_elapsed >= {5'd0, min_dwell_reg});
        end

        if (force_idle)
            flow_state_next = 1'b0;
        else if (apply_want)
            flow_state_next = (want == sfhc_pkg::DS_FLOWING);
        else
            flow_state_next = flow_state_reg;
    end

    // state moves only when a poll word passes into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_state_reg  <= 1'b0;
            desired_reg     <= sfhc_pkg::DS_UNKNOWN;
            dchg_time_reg   <= '0;
            miss_active_reg <= 1'b0;
            miss_start_reg  <= '0;
        end
        else if (advance)
        begin
            flow_state_reg  <= flow_state_next;
            desired_reg     <= desired_next;
            dchg_time_reg   <= dchg_time_next;
            miss_active_reg <= miss_active_next;
            miss_start_reg  <= miss_start_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic              flow_on_reg;
    logic              flow_changed_reg;
    sfhc_pkg::desired_t desired_out_reg;
    sfhc_pkg::reason_t reason_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            flow_on_reg      <= flow_state_next;
            flow_changed_reg <= flow_state_next != flow_state_reg;
            desired_out_reg  <= desired_next;
            reason_reg       <= reason;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.flow_on         = flow_on_reg;
    assign result.flow_changed    = flow_changed_reg;
    assign result.desired_flow    = desired_out_reg;
    assign result.decision_reason = reason_reg;

endmodule
